// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk_i, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is skipped while rst_ni is low
`define PRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds during reset
`define PRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prr_pkg;

  localparam int MAX_USERS  = 8;
  localparam int FIFO_DEPTH = 16;
  localparam int NFIFO      = 2 * MAX_USERS;

  localparam int SLOT_W = $clog2(MAX_USERS);
  localparam int FIFO_W = SLOT_W + 1;
  localparam int LEN_W  = $clog2(MAX_USERS + 1);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = $clog2(NFIFO * FIFO_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [FIFO_W-1:0] fifo_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SERVE  = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_FIFO_FULL  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic pop;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic will_pop;
    logic out_free;
  } sts_t;

endpackage

// ===== design/prr_ctrl.sv =====
// ----------------------------------------------------------------------------
// prr_ctrl
// sequencer that steps one transaction through lookup, execute, an optional pop and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prr_ctrl import prr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_EXEC   = 5'b00100,
    S_POP    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.will_pop ? S_POP : S_DONE;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/prr_dp.sv =====
// ----------------------------------------------------------------------------
// prr_dp
// user table, rotation, fifo pointers, job store and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prr_dp import prr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  op_e           op_i,
  input  logic [7:0]    user_id_i,
  input  logic          is_urgent_i,
  input  logic [15:0]   job_code_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output status_e       status_o,
  output logic [15:0]   served_job_o,
  output logic [7:0]    served_user_o,
  output logic          served_urgent_o
);

  function automatic ptr_t wr_pos(ptr_t head, fill_t fill);
    logic [PTR_W:0] s;
    s = {1'b0, head} + (PTR_W+1)'(fill);
    if (s >= (PTR_W+1)'(FIFO_DEPTH)) s = s - (PTR_W+1)'(FIFO_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t next_ptr(ptr_t head);
    return (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  endfunction

  function automatic addr_t job_addr(fifo_t f, ptr_t p);
    return ADDR_W'(int'(f) * FIFO_DEPTH + int'(p));
  endfunction

  // captured transaction
  op_e         op_q;
  logic [7:0]  user_q;
  logic        urg_q;
  logic [15:0] code_q;

  // user table and rotation
  logic [7:0]           owner_q [MAX_USERS];
  logic [7:0]           owner_d [MAX_USERS];
  logic [MAX_USERS-1:0] in_use_q, in_use_d;
  slot_t                rot_q [MAX_USERS];
  slot_t                rot_d [MAX_USERS];
  len_t                 len_q, len_d, len_m1;

  // fifo pointers
  ptr_t  head_q [NFIFO];
  ptr_t  head_d [NFIFO];
  fill_t fill_q [NFIFO];
  fill_t fill_d [NFIFO];

  // lookup results
  logic  hit, free_ok, rpos_ok;
  slot_t hit_idx, free_idx;
  len_t  rpos;
  logic  found_q, free_ok_q, rpos_ok_q;
  slot_t slot_q, free_q;
  len_t  rpos_q;

  // job store
  logic [15:0] mem [NFIFO * FIFO_DEPTH];
  logic        mem_we, mem_re;
  addr_t       mem_waddr, mem_raddr;
  logic [15:0] rd_q;

  // results
  status_e     res_status_q, res_status_d;
  logic [15:0] res_job_q, res_job_d;
  logic [7:0]  res_user_q, res_user_d;
  logic        res_urg_q, res_urg_d;
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q;
  logic [15:0] out_job_q;
  logic [7:0]  out_user_q;
  logic        out_urg_q;

  // exec helpers
  logic  will_pop;
  logic  rm_en, ap_en, rel_en;
  len_t  rm_pos;
  slot_t ap_idx, ap_slot, rel_slot, fs;
  fifo_t f, fu, fn, pf;
  logic [FILL_W:0] fill_sum;

  // parallel search of the table and the rotation
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    rpos_ok  = 1'b0;
    rpos     = '0;
    for (int i = MAX_USERS - 1; i >= 0; i--) begin
      if (in_use_q[i] && owner_q[i] == user_q) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!in_use_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    for (int i = MAX_USERS - 1; i >= 0; i--) begin
      if (LEN_W'(i) < len_q && rot_q[i] == hit_idx) begin
        rpos_ok = 1'b1;
        rpos    = LEN_W'(i);
      end
    end
  end

  always_comb begin
    owner_d      = owner_q;
    in_use_d     = in_use_q;
    rot_d        = rot_q;
    len_d        = len_q;
    head_d       = head_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_job_d    = res_job_q;
    res_user_d   = res_user_q;
    res_urg_d    = res_urg_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    will_pop     = 1'b0;
    rm_en        = 1'b0;
    rm_pos       = '0;
    ap_en        = 1'b0;
    ap_idx       = '0;
    ap_slot      = '0;
    rel_en       = 1'b0;
    rel_slot     = '0;
    len_m1       = len_q - 1'b1;
    f            = {slot_q, urg_q};
    fs           = rot_q[0];
    fu           = {fs, 1'b1};
    fn           = {fs, 1'b0};
    pf           = (fill_q[fu] != '0) ? fu : fn;
    fill_sum     = {1'b0, fill_q[fu]} + {1'b0, fill_q[fn]};

    if (cmd_i.exec) begin
      res_status_d = ST_OK;
      res_job_d    = '0;
      res_user_d   = '0;
      res_urg_d    = 1'b0;
      case (op_q)
        OP_ADD: begin
          if (found_q) begin
            if (fill_q[f] == FILL_W'(FIFO_DEPTH)) begin
              res_status_d = ST_FIFO_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = job_addr(f, wr_pos(head_q[f], fill_q[f]));
              fill_d[f] = fill_q[f] + 1'b1;
            end
          end else if (len_q == LEN_W'(MAX_USERS) || !free_ok_q) begin
            res_status_d = ST_TABLE_FULL;
          end else begin
            in_use_d[free_q]           = 1'b1;
            owner_d[free_q]            = user_q;
            head_d[{free_q, 1'b0}]     = '0;
            head_d[{free_q, 1'b1}]     = '0;
            fill_d[{free_q, 1'b0}]     = '0;
            fill_d[{free_q, 1'b1}]     = '0;
            fill_d[{free_q, urg_q}]    = FILL_W'(1);
            mem_we    = 1'b1;
            mem_waddr = job_addr({free_q, urg_q}, '0);
            ap_en     = 1'b1;
            ap_idx    = len_q[SLOT_W-1:0];
            ap_slot   = free_q;
            len_d     = len_q + 1'b1;
          end
        end
        OP_SERVE: begin
          if (len_q == '0) begin
            res_status_d = ST_EMPTY;
          end else begin
            rm_en  = 1'b1;
            rm_pos = '0;
            len_d  = len_m1;
            if (fill_q[fu] != '0 || fill_q[fn] != '0) begin
              will_pop   = 1'b1;
              mem_re     = 1'b1;
              mem_raddr  = job_addr(pf, head_q[pf]);
              head_d[pf] = next_ptr(head_q[pf]);
              fill_d[pf] = fill_q[pf] - 1'b1;
              res_user_d = owner_q[fs];
              res_urg_d  = (fill_q[fu] != '0);
              if (fill_sum == (FILL_W+1)'(1)) begin
                rel_en   = 1'b1;
                rel_slot = fs;
              end else begin
                // front user goes back to the tail
                ap_en   = 1'b1;
                ap_idx  = len_m1[SLOT_W-1:0];
                ap_slot = fs;
                len_d   = len_q;
              end
            end else begin
              res_status_d = ST_EMPTY;
              rel_en       = 1'b1;
              rel_slot     = fs;
            end
          end
        end
        OP_CANCEL: begin
          if (!found_q) begin
            res_status_d = ST_UNKNOWN;
          end else begin
            if (rpos_ok_q) begin
              rm_en  = 1'b1;
              rm_pos = rpos_q;
              len_d  = len_m1;
            end
            rel_en   = 1'b1;
            rel_slot = slot_q;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.pop) res_job_d = rd_q;

    // close the gap in the rotation, then append
    for (int i = 0; i < MAX_USERS - 1; i++) begin
      if (rm_en && LEN_W'(i) >= rm_pos && LEN_W'(i + 1) < len_q) rot_d[i] = rot_q[i+1];
    end
    if (ap_en) rot_d[ap_idx] = ap_slot;

    if (rel_en) begin
      in_use_d[rel_slot]         = 1'b0;
      owner_d[rel_slot]          = '0;
      head_d[{rel_slot, 1'b0}]   = '0;
      head_d[{rel_slot, 1'b1}]   = '0;
      fill_d[{rel_slot, 1'b0}]   = '0;
      fill_d[{rel_slot, 1'b1}]   = '0;
    end

    if (cmd_i.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q     <= '{default: '0};
      in_use_q    <= '0;
      len_q       <= '0;
      head_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      owner_q     <= owner_d;
      in_use_q    <= in_use_d;
      len_q       <= len_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q        <= rot_d;
    res_status_q <= res_status_d;
    res_job_q    <= res_job_d;
    res_user_q   <= res_user_d;
    res_urg_q    <= res_urg_d;
    if (cmd_i.capture) begin
      op_q   <= op_i;
      user_q <= user_id_i;
      urg_q  <= is_urgent_i;
      code_q <= job_code_i;
    end
    if (cmd_i.lookup) begin
      found_q   <= hit;
      slot_q    <= hit_idx;
      free_ok_q <= free_ok;
      free_q    <= free_idx;
      rpos_ok_q <= rpos_ok;
      rpos_q    <= rpos;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_job_q    <= res_job_q;
      out_user_q   <= res_user_q;
      out_urg_q    <= res_urg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= code_q;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  assign sts_o.will_pop  = will_pop;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign served_job_o    = out_job_q;
  assign served_user_o   = out_user_q;
  assign served_urgent_o = out_urg_q;

  `PRR_ASSERT(a_len_bound, len_q <= LEN_W'(MAX_USERS), "rotation longer than table")
  `PRR_ASSERT(a_len_matches_use, $countones(in_use_q) == int'(len_q), "rotation and table disagree")
  `PRR_ASSERT(a_pop_after_exec, cmd_i.pop |-> $past(cmd_i.exec), "pop without a preceding read")

endmodule

// ===== design/per_user_round_robin_job_queue.sv =====
// ----------------------------------------------------------------------------
// per_user_round_robin_job_queue
// round-robin job scheduler with an urgent and a normal fifo per user
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The block works on one item
// at a time: the accepting cycle captures it, then come a table lookup cycle,
// an execute cycle, a pop cycle for a serve that pops a job because the job
// store read is registered, and a load cycle, after which the result is valid.
// The next item is taken in the cycle after the load, so a new item is only
// accepted once the last one is through; a result still waiting on the master
// side holds the load cycle. The result register lets a new item enter while the
// last result still waits on the master side. Up to 8 users share 16 fifos of
// 16 jobs each in a 256 x 16 job store; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module per_user_round_robin_job_queue import prr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // user_id[7:0], is_urgent[8], job_code[24:9]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // result transactions
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // served_job[15:0], served_user[23:16], served_urgent[24]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  cmd_t        cmd;
  sts_t        sts;
  status_e     status;
  logic [15:0] served_job;
  logic [7:0]  served_user;
  logic        served_urgent;

  // sequencer: accepts a transaction only when idle
  prr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, job store and output register
  prr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_e'(s_axis_tuser)),
    .user_id_i       (s_axis_tdata[7:0]),
    .is_urgent_i     (s_axis_tdata[8]),
    .job_code_i      (s_axis_tdata[24:9]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (status),
    .served_job_o    (served_job),
    .served_user_o   (served_user),
    .served_urgent_o (served_urgent)
  );

  // pack result fields, zero padded to a whole word
  assign m_axis_tdata = {7'b0, served_urgent, served_user, served_job};
  assign m_axis_tuser = status;

endmodule
